// ===== design/mspw_pkg.sv =====
`timescale 1ns / 1ps

package mspw_pkg;

  localparam int unsigned PeriodW  = 4;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PeriodW-1:0]  PeriodReset  = 4'd10;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;
  localparam logic [TimeoutW-1:0] IdleMax      = 16'hFFFF;

  typedef enum logic {
    REG_PERIOD_TICKS    = 1'b0,
    REG_TIMEOUT_PERIODS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_FORWARD = 2'd0,
    DIR_BACK    = 2'd1
  } dir_code_t;

  typedef struct packed {
    logic              cmd_valid;
    logic signed [7:0] duty;
    logic [1:0]        left_dir;
    logic [1:0]        right_dir;
  } in_item_t;

  typedef struct packed {
    logic cmd_taken;
    logic motor_pin;
    logic left_fwd_pin;
    logic left_back_pin;
    logic right_fwd_pin;
    logic right_back_pin;
    logic duty_error;
    logic direction_error;
  } out_item_t;

  // forward sets the fwd pin, anything else (only back gets here) the back pin
  function automatic logic [1:0] dir_bits(input logic [1:0] code);
    dir_bits = (code == DIR_FORWARD) ? 2'b01 : 2'b10;
  endfunction

endpackage

// ===== design/motor_soft_pwm_with_watchdog_top.sv =====
`timescale 1ns / 1ps

// an input transfer's result is held in the output register from the next cycle
// throughput: one tick per cycle while results drain; a tick is only taken when the
//   output register is empty or its result leaves in the same cycle
// reset (rst, synchronous): pwm counters, idle count and pins cleared, period_ticks 10,
//   timeout_periods 1000, output register empty
module motor_soft_pwm_with_watchdog_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mspw_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mspw_pkg::out_item_t           out_item,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [mspw_pkg::CfgDataW-1:0] cfg_data
);

  logic [mspw_pkg::PeriodW-1:0]  period_ticks;
  logic [mspw_pkg::TimeoutW-1:0] timeout_periods;

  logic [mspw_pkg::PeriodW-1:0]  tick_in_period, tick_in_period_next;
  logic [mspw_pkg::PeriodW-1:0]  duty_countdown, duty_countdown_next;
  logic [mspw_pkg::PeriodW-1:0]  latched_duty, latched_duty_next;
  logic                          pin_level, pin_level_next;
  logic [mspw_pkg::TimeoutW-1:0] idle_periods, idle_periods_next;
  logic [3:0]                    direction_pins, direction_pins_next;

  logic                 in_fire;
  logic                 boundary;
  logic                 duty_bad;
  logic                 dir_bad;
  mspw_pkg::out_item_t  result;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign boundary = tick_in_period >= period_ticks;
  assign duty_bad = in_item.duty < 0 ||
                    in_item.duty > $signed({4'd0, period_ticks});
  assign dir_bad  = in_item.left_dir > mspw_pkg::DIR_BACK ||
                    in_item.right_dir > mspw_pkg::DIR_BACK;

  always_comb begin
    tick_in_period_next = tick_in_period;
    duty_countdown_next = duty_countdown;
    latched_duty_next   = latched_duty;
    pin_level_next      = pin_level;
    idle_periods_next   = idle_periods;
    direction_pins_next = direction_pins;
    result              = '0;

    if (boundary) begin
      if (in_item.cmd_valid) begin
        result.cmd_taken       = 1'b1;
        result.duty_error      = duty_bad;
        result.direction_error = dir_bad;
        duty_countdown_next    = duty_bad ? '0 : in_item.duty[mspw_pkg::PeriodW-1:0];
        if (!dir_bad) begin
          direction_pins_next = {mspw_pkg::dir_bits(in_item.right_dir),
                                 mspw_pkg::dir_bits(in_item.left_dir)};
        end
        idle_periods_next = '0;
        latched_duty_next = duty_countdown_next;
      end else begin
        if (idle_periods != mspw_pkg::IdleMax) begin
          idle_periods_next = idle_periods + 1'b1;
        end
        duty_countdown_next = latched_duty;
      end
      pin_level_next      = duty_countdown_next != '0;
      tick_in_period_next = '0;
    end else begin
      if (duty_countdown != '0) begin
        duty_countdown_next = duty_countdown - 1'b1;
      end else begin
        pin_level_next = 1'b0;
      end
      tick_in_period_next = tick_in_period + 1'b1;
    end

    // watchdog: too many periods without a command forces the motor off
    if (idle_periods_next == timeout_periods && pin_level_next) begin
      latched_duty_next   = '0;
      duty_countdown_next = '0;
      pin_level_next      = 1'b0;
    end

    result.motor_pin      = pin_level_next;
    result.left_fwd_pin   = direction_pins_next[0];
    result.left_back_pin  = direction_pins_next[1];
    result.right_fwd_pin  = direction_pins_next[2];
    result.right_back_pin = direction_pins_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks    <= mspw_pkg::PeriodReset;
      timeout_periods <= mspw_pkg::TimeoutReset;
    end else if (cfg_write) begin
      unique case (mspw_pkg::cfg_reg_t'(cfg_index))
        mspw_pkg::REG_PERIOD_TICKS:
          period_ticks <= cfg_data[mspw_pkg::PeriodW-1:0];
        mspw_pkg::REG_TIMEOUT_PERIODS:
          timeout_periods <= cfg_data[mspw_pkg::TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_in_period <= '0;
      duty_countdown <= '0;
      latched_duty   <= '0;
      pin_level      <= 1'b0;
      idle_periods   <= '0;
      direction_pins <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        tick_in_period <= tick_in_period_next;
        duty_countdown <= duty_countdown_next;
        latched_duty   <= latched_duty_next;
        pin_level      <= pin_level_next;
        idle_periods   <= idle_periods_next;
        direction_pins <= direction_pins_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item <= result;
    end
  end

  // a tick at a boundary always restarts the period
  a_boundary_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && boundary |=> tick_in_period == '0)
    else $error("period did not restart after boundary tick");

  // error flags only answer a taken command
  a_flags_need_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.duty_error || out_item.direction_error) |-> out_item.cmd_taken)
    else $error("error flag without a taken command");

  // the idle count only drops when a command is taken
  a_idle_monotonic: assert property (@(posedge clk) disable iff (rst)
    in_fire && !(boundary && in_item.cmd_valid) |=> idle_periods >= $past(idle_periods))
    else $error("idle count fell without a command");

  // a bad direction code leaves every direction pin as it was
  a_dir_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && boundary && in_item.cmd_valid && dir_bad
      |=> direction_pins == $past(direction_pins))
    else $error("direction pins changed on invalid code");

endmodule
